### rtl/assert_macros.svh
// Assertion helpers shared by the resampler RTL.
// All checks sample on the rising edge of clock and are off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ant holds, cons holds too.
`define LIPR_ASSERT_NOW(label, ant, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ant) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: whenever ant holds, cons holds in the next cycle.
`define LIPR_ASSERT_NEXT(label, ant, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ant) |=> (cons)) \
      else $error(msg);

`endif

### rtl/lipr_pkg.sv
// ----------------------------------------------------------------------------
// lipr_pkg
// Shared widths, constants, types and helpers for the linear interpolation
// PCM resampler.
// ----------------------------------------------------------------------------
`default_nettype none

package lipr_pkg;

   // Fixed point and counter sizes
   localparam int FRAC_W     = 16;
   localparam int COUNT_W    = 24;
   localparam int STEP_W     = 22;
   localparam int TOTAL_W    = 24;
   localparam int SMP_W      = 8;
   localparam int PCM_W      = 16;
   localparam int WIDEN_SHIFT = 8;
   localparam int SILENCE    = 128;
   localparam int BURST_MAX  = 32;

   localparam int PHASE_W = STEP_W + 1;
   localparam int DIFF_W  = PCM_W + 1;
   localparam int PROD_W  = FRAC_W + 1 + DIFF_W;
   localparam int BURST_W = $clog2(BURST_MAX + 1);
   localparam int CMP_W   = (COUNT_W > TOTAL_W) ? COUNT_W : TOTAL_W;
   localparam int CSR_W   = TOTAL_W;

   localparam logic [PHASE_W-1:0] PHASE_ONE  = PHASE_W'(1) << FRAC_W;
   localparam logic [STEP_W-1:0]  STEP_RESET = STEP_W'(PHASE_ONE);

   // Register indexes of the configuration port
   localparam logic [0:0] CSR_PHASE_STEP   = 1'b0;
   localparam logic [0:0] CSR_OUTPUT_TOTAL = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INTERP,
      ST_EMIT,
      ST_FLAT
   } state_type;

   typedef struct packed {
      logic load_item;
      logic finish_item;
      logic emit_interp;
      logic emit_flat;
      logic end_stream;
   } cmd_type;

   typedef struct packed {
      logic interp_ok;
      logic flat_ok;
      logic last_item;
      logic out_free;
   } status_type;

   // Unsigned 8-bit sample to signed 16-bit: (s - 128) << 8
   function automatic logic signed [PCM_W-1:0] widen(input logic [SMP_W-1:0] s);
      return {~s[SMP_W-1], s[SMP_W-2:0], {WIDEN_SHIFT{1'b0}}};
   endfunction

endpackage

`default_nettype wire

### rtl/lipr_datapath.sv
// ----------------------------------------------------------------------------
// lipr_datapath
// Configuration registers, stream state, registered interpolation multiply
// and the output register of the resampler.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lipr_datapath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_enable,
   input  wire logic [0:0]                      csr_index,
   input  wire logic [lipr_pkg::CSR_W-1:0]      csr_wdata,
   input  wire logic [lipr_pkg::SMP_W-1:0]      req_sample_in,
   input  wire logic                            req_last_in,
   input  wire logic                            rsp_stall,
   output logic                                 rsp_valid,
   output logic signed [lipr_pkg::PCM_W-1:0]    rsp_pcm_out,
   output logic                                 rsp_last_out,
   input  wire lipr_pkg::cmd_type               cmd,
   output lipr_pkg::status_type                 status
);

   logic [lipr_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [lipr_pkg::TOTAL_W-1:0]  total_ff, total_in;
   logic [lipr_pkg::SMP_W-1:0]    held_ff, held_in;
   logic                          have_held_ff, have_held_in;
   logic [lipr_pkg::PHASE_W-1:0]  phase_ff, phase_in;
   logic [lipr_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [lipr_pkg::BURST_W-1:0]  burst_ff, burst_in;
   logic [lipr_pkg::SMP_W-1:0]    cur_ff, cur_in;
   logic                          last_ff, last_in;
   logic signed [lipr_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [lipr_pkg::PCM_W-1:0] rsp_pcm_ff, rsp_pcm_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic signed [lipr_pkg::DIFF_W-1:0] cur_wide, prev_wide, diff, interp_sum;
   logic signed [lipr_pkg::PROD_W-1:0] prod_shift;
   logic [lipr_pkg::COUNT_W-1:0]  count_inc;
   logic                          below_one, room, burst_room, hits_total;

   always_comb begin
      cur_wide   = lipr_pkg::DIFF_W'(lipr_pkg::widen(cur_ff));
      prev_wide  = lipr_pkg::DIFF_W'(lipr_pkg::widen(held_ff));
      diff       = cur_wide - prev_wide;
      prod_in    = $signed({1'b0, phase_ff[lipr_pkg::FRAC_W-1:0]}) * diff;
      prod_shift = prod_ff >>> lipr_pkg::FRAC_W;
      interp_sum = prev_wide + prod_shift[lipr_pkg::DIFF_W-1:0];

      below_one  = (phase_ff[lipr_pkg::PHASE_W-1:lipr_pkg::FRAC_W] == '0);
      room       = lipr_pkg::CMP_W'(count_ff) < lipr_pkg::CMP_W'(total_ff);
      burst_room = burst_ff < lipr_pkg::BURST_W'(lipr_pkg::BURST_MAX);
      count_inc  = count_ff + lipr_pkg::COUNT_W'(1);
      hits_total = lipr_pkg::CMP_W'(count_inc) == lipr_pkg::CMP_W'(total_ff);

      status.interp_ok = have_held_ff & below_one & room & burst_room;
      status.flat_ok   = room & burst_room;
      status.last_item = last_ff;
      status.out_free  = ~rsp_valid_ff | ~rsp_stall;
   end

   always_comb begin
      step_in      = step_ff;
      total_in     = total_ff;
      held_in      = held_ff;
      have_held_in = have_held_ff;
      phase_in     = phase_ff;
      count_in     = count_ff;
      burst_in     = burst_ff;
      cur_in       = cur_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_pcm_in   = rsp_pcm_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_write_enable) begin
         case (csr_index)
            lipr_pkg::CSR_PHASE_STEP:   step_in  = csr_wdata[lipr_pkg::STEP_W-1:0];
            lipr_pkg::CSR_OUTPUT_TOTAL: total_in = csr_wdata[lipr_pkg::TOTAL_W-1:0];
            default: ;
         endcase
      end

      if (cmd.load_item) begin
         cur_in   = req_sample_in;
         last_in  = req_last_in;
         burst_in = '0;
      end

      if (cmd.emit_interp) begin
         rsp_valid_in = 1'b1;
         rsp_pcm_in   = interp_sum[lipr_pkg::PCM_W-1:0];
         rsp_last_in  = hits_total;
         count_in     = count_inc;
         phase_in     = phase_ff + lipr_pkg::PHASE_W'(step_ff);
         burst_in     = burst_ff + lipr_pkg::BURST_W'(1);
      end

      if (cmd.finish_item) begin
         if (!below_one) begin
            phase_in = phase_ff - lipr_pkg::PHASE_ONE;
         end
         held_in      = cur_ff;
         have_held_in = 1'b1;
         burst_in     = '0;
      end

      if (cmd.emit_flat) begin
         rsp_valid_in = 1'b1;
         rsp_pcm_in   = lipr_pkg::widen(cur_ff);
         // final flag also on the last copy of a capped burst
         rsp_last_in  = hits_total |
                        (burst_ff == lipr_pkg::BURST_W'(lipr_pkg::BURST_MAX - 1));
         count_in     = count_inc;
         burst_in     = burst_ff + lipr_pkg::BURST_W'(1);
      end

      if (cmd.end_stream) begin
         held_in      = lipr_pkg::SMP_W'(lipr_pkg::SILENCE);
         have_held_in = 1'b0;
         phase_in     = '0;
         count_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= lipr_pkg::STEP_RESET;
         total_ff     <= '0;
         held_ff      <= lipr_pkg::SMP_W'(lipr_pkg::SILENCE);
         have_held_ff <= 1'b0;
         phase_ff     <= '0;
         count_ff     <= '0;
         burst_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         total_ff     <= total_in;
         held_ff      <= held_in;
         have_held_ff <= have_held_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         burst_ff     <= burst_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      last_ff     <= last_in;
      prod_ff     <= prod_in;
      rsp_pcm_ff  <= rsp_pcm_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_pcm_out  = rsp_pcm_ff;
   assign rsp_last_out = rsp_last_ff;

   `LIPR_ASSERT_NEXT(a_count_step, cmd.emit_interp || cmd.emit_flat, count_ff == $past(count_ff) + lipr_pkg::COUNT_W'(1), "emitted count did not advance by one")
   `LIPR_ASSERT_NOW(a_burst_cap, 1'b1, burst_ff <= lipr_pkg::BURST_W'(lipr_pkg::BURST_MAX), "burst counter past its limit")
   `LIPR_ASSERT_NEXT(a_end_clear, cmd.end_stream, !have_held_ff && count_ff == '0 && phase_ff == '0, "stream state not cleared at end of stream")

endmodule

`default_nettype wire

### rtl/lipr_ctrl.sv
// ----------------------------------------------------------------------------
// lipr_ctrl
// Sequencer: accepts an item, walks the interpolation burst, then the flat
// tail of a stream, and issues commands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lipr_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire lipr_pkg::status_type status,
   output lipr_pkg::cmd_type         cmd
);

   lipr_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lipr_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = lipr_pkg::ST_INTERP;
            end
         end
         lipr_pkg::ST_INTERP: begin
            if (status.interp_ok) begin
               state_in = lipr_pkg::ST_EMIT;
            end else if (status.last_item) begin
               state_in = lipr_pkg::ST_FLAT;
            end else begin
               state_in = lipr_pkg::ST_IDLE;
            end
         end
         lipr_pkg::ST_EMIT: begin
            if (status.out_free) begin
               state_in = lipr_pkg::ST_INTERP;
            end
         end
         lipr_pkg::ST_FLAT: begin
            if (!status.flat_ok) begin
               state_in = lipr_pkg::ST_IDLE;
            end
         end
         default: state_in = lipr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         lipr_pkg::ST_IDLE: begin
            req_stall     = 1'b0;
            cmd.load_item = req_valid;
         end
         lipr_pkg::ST_INTERP: begin
            cmd.finish_item = ~status.interp_ok;
         end
         lipr_pkg::ST_EMIT: begin
            cmd.emit_interp = status.out_free;
         end
         lipr_pkg::ST_FLAT: begin
            cmd.emit_flat  = status.flat_ok & status.out_free;
            cmd.end_stream = ~status.flat_ok;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lipr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `LIPR_ASSERT_NOW(a_emit_free, cmd.emit_interp || cmd.emit_flat, status.out_free, "output register overwritten while full")
   `LIPR_ASSERT_NOW(a_one_cmd, 1'b1, $onehot0({cmd.load_item, cmd.finish_item, cmd.emit_interp, cmd.emit_flat, cmd.end_stream}), "more than one datapath command at once")

endmodule

`default_nettype wire

### rtl/linear_interp_pcm_resampler_unit.sv
// ----------------------------------------------------------------------------
// Sequence: an item is taken only in idle; each interpolated output passes interpolate, then
// emit, which waits for a free output register and writes it. Flat outputs follow in flat.
// The interpolation multiply is registered, which is why interpolate and emit alternate.
// Reset: synchronous, clears state, phase_step = 1.0, output_total = 0.
// ----------------------------------------------------------------------------
`default_nettype none

// linear_interp_pcm_resampler_unit
// Linear interpolation resampler for unsigned 8-bit PCM. Each accepted item
// (after the first of a stream) produces up to 32 interpolated outputs between
// the held sample and the new one, stepping a 7.16 phase. The final item of
// a stream adds up to 32 flat copies of itself until output_total is reached.
// The final output of a stream carries rsp_last_out.

module linear_interp_pcm_resampler_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // configuration port: index 0 phase_step, index 1 output_total
   input  wire logic                                csr_write_enable,
   input  wire logic [0:0]                          csr_index,
   input  wire logic [lipr_pkg::CSR_W-1:0]          csr_wdata,
   // input samples
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [lipr_pkg::SMP_W-1:0]          req_sample_in,
   input  wire logic                                req_last_in,
   // output samples
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [lipr_pkg::PCM_W-1:0]        rsp_pcm_out,
   output logic                                     rsp_last_out
);

   lipr_pkg::cmd_type    cmd;
   lipr_pkg::status_type status;

   // Sequencer: hold off new items while a burst is in progress; one
   // output goes into the output register per emit command.
   lipr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: registers, phase accumulator, multiply and output register.
   // The output register frees the input side while a result waits.
   lipr_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_sample_in    (req_sample_in),
      .req_last_in      (req_last_in),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_pcm_out      (rsp_pcm_out),
      .rsp_last_out     (rsp_last_out),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: linear interpolation PCM resampler testbench
// Drives 8-bit PCM streams through linear_interp_pcm_resampler_unit under
// random idling on both channels and checks every output sample, in order,
// against a cycle-free model of the interpolator kept in this file.
// ----------------------------------------------------------------------------
module tb_top;
   import lipr_pkg::*;

   // Hard stop. The slowest legal run (every item at 64 outputs, every output
   // behind the longest stall) stays well below this.
   localparam int CYCLE_LIMIT   = 2_000_000;
   // Cycles to let pass after the last expected output before a register
   // write or the end, so an item that makes no output can finish.
   localparam int SETTLE_CYCLES = 12;
   localparam int RAND_ITEMS    = 40;   // items per random register setting
   localparam int RAND_PHASES   = 7;
   localparam logic [31:0] UNITY = 32'd1 << FRAC_W;

   typedef struct packed {
      logic signed [PCM_W-1:0] pcm;
      logic                    last;
   } pcm_result_t;

   // One line of the directed plan: either a register write or an item.
   // Where typed is set, the outputs are written in by hand: n copies of pcm,
   // with last_out only on the final one and only if fin is set.
   typedef struct packed {
      bit                  is_cfg;
      logic [0:0]          reg_idx;
      logic [TOTAL_W-1:0]  value;
      logic [SMP_W-1:0]    smp;
      bit                  lst;
      bit                  typed;
      logic [6:0]          n;
      logic [PCM_W-1:0]    pcm;
      bit                  fin;
   } plan_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               csr_write_enable = 1'b0;
   logic [0:0]         csr_index        = CSR_PHASE_STEP;
   logic [CSR_W-1:0]   csr_wdata        = '0;
   logic               req_valid        = 1'b0;
   logic               req_stall;
   logic [SMP_W-1:0]   req_sample_in    = '0;
   logic               req_last_in      = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall        = 1'b0;
   logic signed [PCM_W-1:0] rsp_pcm_out;
   logic               rsp_last_out;

   // Predictor state and its copy of the registers
   logic [SMP_W-1:0]   rs_held    = SMP_W'(SILENCE);
   bit                 rs_primed  = 1'b0;
   logic [31:0]        rs_phase   = '0;
   logic [COUNT_W-1:0] rs_count   = '0;
   logic [STEP_W-1:0]  cfg_step   = STEP_W'(UNITY);
   logic [TOTAL_W-1:0] cfg_total  = '0;

   pcm_result_t pred_q[$];          // outputs of the item just predicted
   pcm_result_t pcm_expect_q[$];    // outputs still owed by the block

   int  fail_count  = 0;
   int  rsp_seen    = 0;
   int  items_sent  = 0;
   int  cfg_writes  = 0;
   int  cycle_count = 0;
   int  stall_run   = 0;
   bit  req_calm    = 1'b0;

   linear_interp_pcm_resampler_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_in    (req_sample_in),
      .req_last_in      (req_last_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pcm_out      (rsp_pcm_out),
      .rsp_last_out     (rsp_last_out)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Directed plan: reset values, both ends of the output total, a zero step,
   // the count limit, a total lowered below the count mid-stream, single-
   // sample streams, the largest burst (32 interpolated + 32 flat outputs).
   plan_row_t dir_plan [31] = '{
      // total 0 after reset: a whole stream gives nothing
      '{1'b0, CSR_PHASE_STEP,   24'd0,      8'h80, 1'b1, 1'b1, 7'd0,  16'h0000, 1'b0},
      '{1'b1, CSR_OUTPUT_TOTAL, 24'd4,      8'h00, 1'b0, 1'b0, 7'd0,  16'h0000, 1'b0},
      // first sample only primes
      '{1'b0, CSR_PHASE_STEP,   24'd0,      8'hFF, 1'b0, 1'b1, 7'd0,  16'h0000, 1'b0},
      '{1'b0, CSR_PHASE_STEP,   24'd0,      8'hFF, 1'b0, 1'b1, 7'd1,  16'h7F00, 1'b0},
      // stream ends on the total: interpolated then flat outputs
      '{1'b0, CSR_PHASE_STEP,   24'd0,      8'h00, 1'b1, 1'b0, 7'd0,  16'h0000, 1'b0},
      '{1'b1, CSR_PHASE_STEP,   24'd2048,   8'h00, 1'b0, 1'b0, 7'd0,  16'h0000, 1'b0},
      '{1'b1, CSR_OUTPUT_TOTAL, 24'hFFFFFF, 8'h00, 1'b0, 1'b0, 7'd0,  16'h0000, 1'b0},
      '{1'b0, CSR_PHASE_STEP,   24'd0,      8'h00, 1'b0, 1'b1, 7'd0,  16'h0000, 1'b0},
      '{1'b0, CSR_PHASE_STEP,   24'd0,      8'hFF, 1'b0, 1'b0, 7'd0,  16'h0000, 1'b0},
      '{1'b0, CSR_PHASE_STEP,   24'd0,      8'h7F, 1'b0, 1'b0, 7'd0,  16'h0000, 1'b0},
      // step of 1/32: full interpolated burst plus full flat burst
      '{1'b0, CSR_PHASE_STEP,   24'd0,      8'h01, 1'b1, 1'b0, 7'd0,  16'h0000, 1'b0},
      '{1'b1, CSR_PHASE_STEP,   24'd2097152, 8'h00, 1'b0, 1'b0, 7'd0, 16'h0000, 1'b0},
      // step of 32.0: one output, then inputs are skipped
      '{1'b0, CSR_PHASE_STEP,   24'd0,      8'h55, 1'b0, 1'b1, 7'd0,  16'h0000, 1'b0},
      '{1'b0, CSR_PHASE_STEP,   24'd0,      8'hAA, 1'b0, 1'b1, 7'd1,  16'hD500, 1'b0},
      '{1'b0, CSR_PHASE_STEP,   24'd0,      8'h00, 1'b0, 1'b1, 7'd0,  16'h0000, 1'b0},
      '{1'b0, CSR_PHASE_STEP,   24'd0,      8'hFF, 1'b1, 1'b1, 7'd32, 16'h7F00, 1'b1},
      '{1'b1, CSR_PHASE_STEP,   24'h008000, 8'h00, 1'b0, 1'b0, 7'd0,  16'h0000, 1'b0},
      '{1'b1, CSR_OUTPUT_TOTAL, 24'd5,      8'h00, 1'b0, 1'b0, 7'd0,  16'h0000, 1'b0},
      '{1'b0, CSR_PHASE_STEP,   24'd0,      8'h80, 1'b0, 1'b1, 7'd0,  16'h0000, 1'b0},
      '{1'b0, CSR_PHASE_STEP,   24'd0,      8'hC0, 1'b0, 1'b0, 7'd0,  16'h0000, 1'b0},
      '{1'b0, CSR_PHASE_STEP,   24'd0,      8'h40, 1'b0, 1'b0, 7'd0,  16'h0000, 1'b0},
      '{1'b0, CSR_PHASE_STEP,   24'd0,      8'h20, 1'b0, 1'b0, 7'd0,  16'h0000, 1'b0},
      // count reached: silence until the total moves
      '{1'b0, CSR_PHASE_STEP,   24'd0,      8'h10, 1'b0, 1'b1, 7'd0,  16'h0000, 1'b0},
      '{1'b1, CSR_OUTPUT_TOTAL, 24'd2,      8'h00, 1'b0, 1'b0, 7'd0,  16'h0000, 1'b0},
      '{1'b0, CSR_PHASE_STEP,   24'd0,      8'h90, 1'b1, 1'b1, 7'd0,  16'h0000, 1'b0},
      // zero step: the phase never moves, bursts cap at 32
      '{1'b1, CSR_PHASE_STEP,   24'd0,      8'h00, 1'b0, 1'b0, 7'd0,  16'h0000, 1'b0},
      '{1'b1, CSR_OUTPUT_TOTAL, 24'd40,     8'h00, 1'b0, 1'b0, 7'd0,  16'h0000, 1'b0},
      '{1'b0, CSR_PHASE_STEP,   24'd0,      8'h00, 1'b0, 1'b1, 7'd0,  16'h0000, 1'b0},
      '{1'b0, CSR_PHASE_STEP,   24'd0,      8'hFF, 1'b0, 1'b1, 7'd32, 16'h8000, 1'b0},
      '{1'b0, CSR_PHASE_STEP,   24'd0,      8'h12, 1'b1, 1'b1, 7'd8,  16'h7F00, 1'b1},
      // one-sample stream: flat outputs only
      '{1'b0, CSR_PHASE_STEP,   24'd0,      8'h00, 1'b1, 1'b1, 7'd32, 16'h8000, 1'b1}
   };

   // Count one output and flag it when it reaches the total.
   task automatic push_result(input int v);
      rs_count = rs_count + 1'b1;
      pred_q.push_back('{pcm: v[PCM_W-1:0], last: (rs_count == cfg_total)});
   endtask

   // Work out the outputs of one accepted sample into pred_q and advance
   // the stream state.
   task automatic predict_item(input logic [SMP_W-1:0] smp, input bit lst);
      int     cur;
      int     prev;
      int     n;
      longint prod;
      pred_q.delete();
      cur = (int'(smp) - SILENCE) * (1 << WIDEN_SHIFT);
      if (rs_primed) begin
         prev = (int'(rs_held) - SILENCE) * (1 << WIDEN_SHIFT);
         n = 0;
         while (rs_phase < UNITY && rs_count < cfg_total && n < BURST_MAX) begin
            // arithmetic shift floors toward minus infinity
            prod = longint'(rs_phase) * longint'(cur - prev);
            push_result(prev + int'(prod >>> FRAC_W));
            rs_phase = rs_phase + cfg_step;
            n++;
         end
         if (rs_phase >= UNITY)
            rs_phase = rs_phase - UNITY;
      end
      rs_held   = smp;
      rs_primed = 1'b1;
      if (lst) begin
         n = 0;
         while (rs_count < cfg_total && n < BURST_MAX) begin
            push_result(cur);
            n++;
         end
         if (pred_q.size() > 0)
            pred_q[pred_q.size()-1].last = 1'b1;
         rs_held   = SMP_W'(SILENCE);
         rs_primed = 1'b0;
         rs_phase  = '0;
         rs_count  = '0;
      end
   endtask

   function automatic int pick_gap();
      int r;
      if (req_calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Present one item after a random gap; return at the edge that takes it.
   task automatic send_item(input logic [SMP_W-1:0] smp, input bit lst);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= smp;
      req_last_in   <= lst;
      do
         @(posedge clock);
      while (req_stall);
      items_sent++;
   endtask

   // Write a register once the block has drained: all owed outputs seen,
   // then a settling wait for an item that makes no output.
   task automatic write_reg(input logic [0:0] idx, input logic [CSR_W-1:0] val);
      req_valid <= 1'b0;
      while (pcm_expect_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_PHASE_STEP)
         cfg_step = val[STEP_W-1:0];
      else
         cfg_total = val[TOTAL_W-1:0];
      cfg_writes++;
   endtask

   // Receiver: alternate stall runs (mostly short, a few long) with open
   // stretches, some of them long enough to stream without any stall.
   always @(posedge clock) begin
      if (stall_run != 0) begin
         stall_run <= stall_run - 1;
      end else if ($urandom_range(0, 2) == 0) begin
         rsp_stall <= 1'b1;
         stall_run <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                 : $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
         stall_run <= ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(0, 4);
      end
   end

   // Check each taken output against the oldest one owed.
   always @(posedge clock) begin : check_outputs
      pcm_result_t owed;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (pcm_expect_q.size() == 0) begin
            $error("unexpected output: pcm_out=%0d last_out=%0b", rsp_pcm_out, rsp_last_out);
            fail_count++;
         end else begin
            owed = pcm_expect_q.pop_front();
            if (rsp_pcm_out !== owed.pcm) begin
               $error("pcm_out mismatch: expected %0d, got %0d", owed.pcm, rsp_pcm_out);
               fail_count++;
            end
            if (rsp_last_out !== owed.last) begin
               $error("last_out mismatch: expected %0b, got %0b", owed.last, rsp_last_out);
               fail_count++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d outputs still owed",
                  cycle_count, pcm_expect_q.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int                 k;
      int                 ph;
      int                 sent;
      int                 len;
      int                 seen_base;
      bit                 broken;
      logic [STEP_W-1:0]  step;
      logic [TOTAL_W-1:0] total;
      logic [SMP_W-1:0]   smp;

      // hold reset from the start, then release it once
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: walk the plan; hand-typed rows override the predictor
      // output but still advance its state.
      foreach (dir_plan[r]) begin
         if (dir_plan[r].is_cfg) begin
            write_reg(dir_plan[r].reg_idx, dir_plan[r].value);
         end else begin
            send_item(dir_plan[r].smp, dir_plan[r].lst);
            predict_item(dir_plan[r].smp, dir_plan[r].lst);
            if (dir_plan[r].typed) begin
               for (k = 0; k < dir_plan[r].n; k++)
                  pcm_expect_q.push_back('{pcm: dir_plan[r].pcm,
                                          last: (k == dir_plan[r].n - 1) && dir_plan[r].fin});
            end else begin
               foreach (pred_q[j])
                  pcm_expect_q.push_back(pred_q[j]);
            end
         end
      end

      // Random part: one register setting per phase, then mostly whole
      // streams with random content; a few streams are cut off without a
      // last sample so the next setting lands mid-stream.
      seen_base = rsp_seen;
      for (ph = 0; ph < RAND_PHASES || rsp_seen - seen_base < 60; ph++) begin
         case (ph)
            0: begin step = 22'd2048;    total = '1;                        end
            1: begin step = 22'd2097152; total = '1;                        end
            2: begin step = STEP_W'(UNITY); total = '0;                     end
            3: begin step = $urandom_range(0, 2047); total = $urandom_range(1, 50); end
            default: begin
               case ($urandom_range(0, 3))
                  0: step = $urandom_range(2048, 2097152);
                  1: step = $urandom_range(UNITY, 2 * UNITY);
                  default: step = $urandom_range(2048, UNITY);
               endcase
               case ($urandom_range(0, 3))
                  0: total = $urandom_range(1, 60);
                  1: total = $urandom;
                  default: total = $urandom_range(200, 5000);
               endcase
            end
         endcase
         write_reg(CSR_PHASE_STEP, CSR_W'(step));
         write_reg(CSR_OUTPUT_TOTAL, CSR_W'(total));
         req_calm = ($urandom_range(0, 3) == 0);
         sent = 0;
         while (sent < RAND_ITEMS) begin
            case ($urandom_range(0, 9))
               0:       len = 1;
               8, 9:    len = $urandom_range(15, 40);
               default: len = $urandom_range(2, 10);
            endcase
            broken = ($urandom_range(0, 9) == 0);
            for (k = 0; k < len && sent < RAND_ITEMS; k++) begin
               if ($urandom_range(0, 7) == 0) begin
                  case ($urandom_range(0, 3))
                     0: smp = 8'h00;
                     1: smp = 8'hFF;
                     2: smp = 8'h80;
                     default: smp = 8'h7F;
                  endcase
               end else begin
                  smp = $urandom_range(0, 255);
               end
               send_item(smp, !broken && (k == len - 1));
               predict_item(smp, !broken && (k == len - 1));
               foreach (pred_q[j])
                  pcm_expect_q.push_back(pred_q[j]);
               sent++;
            end
         end
      end

      // Drain: drop valid, wait for every owed output, then a short tail to
      // catch anything extra.
      req_valid <= 1'b0;
      while (pcm_expect_q.size() != 0)
         @(posedge clock);
      repeat (4 * SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d samples and %0d register writes over %0d random settings;",
               items_sent, cfg_writes, ph);
      $display("%0d output samples were checked in %0d cycles.", rsp_seen, cycle_count);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
